// ===== hdl/lcdnws_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdnws_pkg
// Types, codes and constants shared by the character LCD nibble write
// sequencer: request and pin state payloads, controller/datapath links.
// ----------------------------------------------------------------------------
package lcdnws_pkg;

  // Request codes
  typedef enum logic [1:0] {
    CMD_POWER_UP    = 2'd0,
    CMD_INSTRUCTION = 2'd1,
    CMD_CHARACTER   = 2'd2,
    CMD_SET_CURSOR  = 2'd3
  } command_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_STROBE_HOLD   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_POWER_UP_WAIT = 8'd1;

  localparam logic [7:0] STROBE_HOLD_RESET   = 8'd2;
  localparam logic [7:0] POWER_UP_WAIT_RESET = 8'd20;

  // Power-up sequence
  localparam int unsigned PuCount = 6;
  localparam logic [2:0]  PU_LAST_STEP = 3'(PuCount - 1);

  // Cursor addressing
  localparam logic [7:0] LINE_ONE       = 8'd1;
  localparam logic [7:0] LINE_TWO       = 8'd2;
  localparam logic [7:0] CURSOR_LINE_ONE = 8'h80;
  localparam logic [7:0] CURSOR_LINE_TWO = 8'hC0;
  localparam logic [7:0] COLUMN_MASK     = 8'h0F;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] value;
    logic [7:0] line;
    logic [7:0] column;
  } req_t;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       register_select;
    logic       enable_level;
    logic       read_write;
    logic [7:0] settle_before_ms;
    logic [7:0] hold_ms;
    logic       last;
  } pin_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_acts;
    logic out_free;
    logic last_pin;
    logic final_byte;
  } dp_status_t;

  // Power-up instruction bytes in order
  function automatic logic [7:0] pu_byte(input logic [2:0] step);
    logic [7:0] b;
    case (step)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h0C;
      3'd5:    b = 8'h01;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/lcdnws_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcdnws_ctrl
// Sequencer state machine: takes a request, then steps the datapath through
// its pin states one per free output slot.
// ----------------------------------------------------------------------------
module lcdnws_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lcdnws_pkg::dp_status_t status_i,
  output lcdnws_pkg::dp_cmd_t    cmd_o
);

  lcdnws_pkg::state_e state_q, state_d;
  logic               take;
  logic               step;

  assign take = (state_q == lcdnws_pkg::ST_IDLE) && in_valid_i;
  assign step = (state_q == lcdnws_pkg::ST_RUN) && status_i.out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcdnws_pkg::ST_IDLE: begin
        if (take && status_i.req_acts) begin
          state_d = lcdnws_pkg::ST_RUN;
        end
      end
      lcdnws_pkg::ST_RUN: begin
        if (step && status_i.last_pin && status_i.final_byte) begin
          state_d = lcdnws_pkg::ST_IDLE;
        end
      end
      default: state_d = lcdnws_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      lcdnws_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = take;
      end
      lcdnws_pkg::ST_RUN: begin
        cmd_o.emit = step;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcdnws_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/lcdnws_dp.sv =====
// ----------------------------------------------------------------------------
// lcdnws_dp
// Datapath: configuration registers, current byte, power-up step and pin
// counters, pin state formatting and the output register.
// ----------------------------------------------------------------------------
module lcdnws_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [lcdnws_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  input  lcdnws_pkg::req_t                    req_i,
  input  lcdnws_pkg::dp_cmd_t                 cmd_i,
  output lcdnws_pkg::dp_status_t              status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lcdnws_pkg::pin_t                    out_data_o
);

  logic [7:0]       strobe_q;
  logic [7:0]       pu_wait_q;
  logic             pu_mode_q, pu_mode_d;
  logic [7:0]       byte_q, byte_d;
  logic             rs_q, rs_d;
  logic [2:0]       step_q, step_d;
  logic [1:0]       pin_q, pin_d;
  logic             out_valid_q, out_valid_d;
  lcdnws_pkg::pin_t out_q;
  lcdnws_pkg::pin_t pin_state;
  logic [7:0]       cur_byte;
  logic [7:0]       hold_ext;
  logic [8:0]       hold_sum;
  logic             extra_hold;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q  <= lcdnws_pkg::STROBE_HOLD_RESET;
      pu_wait_q <= lcdnws_pkg::POWER_UP_WAIT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == lcdnws_pkg::CFG_STROBE_HOLD) begin
        strobe_q <= cfg_data_i;
      end else if (cfg_index_i == lcdnws_pkg::CFG_POWER_UP_WAIT) begin
        pu_wait_q <= cfg_data_i;
      end
    end
  end

  // Decide whether the request produces any pin state
  assign status_o.req_acts   = (req_i.command != lcdnws_pkg::CMD_SET_CURSOR) ||
                               (req_i.line == lcdnws_pkg::LINE_ONE) ||
                               (req_i.line == lcdnws_pkg::LINE_TWO);

  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.last_pin   = (pin_q == 2'd3);
  assign status_o.final_byte = !pu_mode_q || (step_q == lcdnws_pkg::PU_LAST_STEP);

  // Load a request; advance the pin counter on each emitted state and the power-up step after each byte's last one
  always_comb begin
    pu_mode_d = pu_mode_q;
    byte_d    = byte_q;
    rs_d      = rs_q;
    step_d    = step_q;
    pin_d     = pin_q;
    if (cmd_i.load) begin
      pu_mode_d = 1'b0;
      rs_d      = 1'b0;
      step_d    = '0;
      pin_d     = '0;
      byte_d    = req_i.value;
      case (req_i.command)
        lcdnws_pkg::CMD_POWER_UP:    pu_mode_d = 1'b1;
        lcdnws_pkg::CMD_INSTRUCTION: byte_d = req_i.value;
        lcdnws_pkg::CMD_CHARACTER:   rs_d = 1'b1;
        lcdnws_pkg::CMD_SET_CURSOR: begin
          if (req_i.line == lcdnws_pkg::LINE_ONE) begin
            byte_d = lcdnws_pkg::CURSOR_LINE_ONE | (req_i.column & lcdnws_pkg::COLUMN_MASK);
          end else begin
            byte_d = lcdnws_pkg::CURSOR_LINE_TWO | (req_i.column & lcdnws_pkg::COLUMN_MASK);
          end
        end
        default: pu_mode_d = 1'b0;
      endcase
    end else if (cmd_i.emit) begin
      pin_d = pin_q + 2'd1;
      if (status_o.last_pin && !status_o.final_byte) begin
        step_d = step_q + 3'd1;
      end
    end
  end

  // Format the pin state of the current byte
  assign cur_byte   = pu_mode_q ? lcdnws_pkg::pu_byte(step_q) : byte_q;
  assign extra_hold = pu_mode_q && status_o.last_pin &&
                      ((step_q == 3'd0) || (step_q == lcdnws_pkg::PU_LAST_STEP));
  assign hold_sum   = {1'b0, strobe_q} + {1'b0, strobe_q};
  assign hold_ext   = hold_sum[8] ? 8'hFF : hold_sum[7:0];

  always_comb begin
    pin_state.data_nibble      = pin_q[1] ? cur_byte[3:0] : cur_byte[7:4];
    pin_state.register_select  = rs_q;
    pin_state.enable_level     = pin_q[0];
    pin_state.read_write       = 1'b0;
    pin_state.settle_before_ms = (pu_mode_q && (step_q == 3'd0) && (pin_q == 2'd0)) ?
                                 pu_wait_q : 8'd0;
    pin_state.hold_ms          = extra_hold ? hold_ext : strobe_q;
    pin_state.last             = status_o.last_pin && status_o.final_byte;
  end

  // Hold the output until taken; refill on emit
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pu_mode_q   <= 1'b0;
      step_q      <= '0;
      pin_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pu_mode_q   <= pu_mode_d;
      step_q      <= step_d;
      pin_q       <= pin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rs_q   <= rs_d;
    if (cmd_i.emit) begin
      out_q <= pin_state;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/char_lcd_nibble_write_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit
// Expands LCD requests into 4-bit bus pin states for an HD44780-style display.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   in      | input     | in_valid / in_stall | lcdnws_pkg::req_t
//   out     | output    | out_valid/out_stall | lcdnws_pkg::pin_t
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A request is taken while idle; from the next cycle one pin state a cycle
// enters the output register while it is free: 4 for a byte, 24 for power-up.
// The next request is taken in the cycle after the last pin state is loaded.
// A cursor request on another line is taken and gives nothing. out_stall_i
// freezes the pin counter while the output register holds a pin state.
// Reset restores the configuration defaults.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lcdnws_pkg::req_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lcdnws_pkg::pin_t               out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lcdnws_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  lcdnws_pkg::dp_cmd_t    dp_cmd;
  lcdnws_pkg::dp_status_t dp_status;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  lcdnws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  lcdnws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (in_data_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/lcdnws_chk.sv =====
// ----------------------------------------------------------------------------
// lcdnws_chk
// Port-level checks on the sequencer's pin state stream, bound to the top.
// ----------------------------------------------------------------------------
module lcdnws_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input lcdnws_pkg::pin_t out_data_o
);

  // Hold a stalled transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // The final state of a request always has enable high
  a_last_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.enable_level)
    else $error("last pin state with enable low");

  // Only writes are issued
  a_write_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.read_write)
    else $error("read/write pin driven high");

  // A settle wait only opens the power-up sequence
  a_settle_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.settle_before_ms != 8'd0) |->
      !out_data_o.enable_level && !out_data_o.register_select &&
      (out_data_o.data_nibble == 4'h3))
    else $error("settle wait outside power-up start");

endmodule

bind char_lcd_nibble_write_sequencer_unit lcdnws_chk u_lcdnws_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== bench/char_lcd_nibble_write_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit_tb
// Self-checking bench for the LCD nibble write sequencer. Requests are
// expanded into expected pin states by a scoreboard that tracks the strobe
// and power-up timing registers. Every pin state leaving the block is
// compared field by field with the oldest expectation. A short directed run
// covers the extremes and corner cases. Random phases follow with reshuffled
// timing registers, random sender gaps and receiver stalls, and one long
// receiver hold that backs the block up.
// ----------------------------------------------------------------------------

class lcd_pin_scoreboard;
  logic [7:0]         strobe_hold;
  logic [7:0]         power_up_wait;
  lcdnws_pkg::pin_t   expected_pins[$];
  int unsigned        mismatches;

  function new();
    strobe_hold   = lcdnws_pkg::STROBE_HOLD_RESET;
    power_up_wait = lcdnws_pkg::POWER_UP_WAIT_RESET;
    mismatches    = 0;
  endfunction

  // Track the timing registers; other indexes leave them alone
  function void note_register(logic [lcdnws_pkg::CfgIdxW-1:0] index, logic [7:0] data);
    if (index == lcdnws_pkg::CFG_STROBE_HOLD) begin
      strobe_hold = data;
    end else if (index == lcdnws_pkg::CFG_POWER_UP_WAIT) begin
      power_up_wait = data;
    end
  endfunction

  // Queue one byte: high nibble then low, each with enable low then high
  function void queue_byte(logic [7:0] b, logic rs, logic [7:0] settle,
                           logic [7:0] extra, bit final_byte);
    lcdnws_pkg::pin_t p;
    logic [8:0]       sum;
    sum = {1'b0, strobe_hold} + {1'b0, extra};
    for (int i = 0; i < 4; i++) begin
      p.data_nibble      = (i < 2) ? b[7:4] : b[3:0];
      p.register_select  = rs;
      p.enable_level     = (i % 2 == 1);
      p.read_write       = 1'b0;
      p.settle_before_ms = (i == 0) ? settle : 8'd0;
      p.hold_ms          = (i == 3) ? (sum[8] ? 8'hFF : sum[7:0]) : strobe_hold;
      p.last             = (i == 3) && final_byte;
      expected_pins.push_back(p);
    end
  endfunction

  // Expand one accepted request into its pin states
  function void note_request(lcdnws_pkg::req_t r);
    logic [7:0] init_seq [6];
    logic [7:0] extra;
    init_seq = '{8'h33, 8'h32, 8'h28, 8'h06, 8'h0C, 8'h01};
    case (r.command)
      lcdnws_pkg::CMD_POWER_UP: begin
        // extra hold after the first and the final instruction only
        for (int s = 0; s < 6; s++) begin
          extra = (s == 0 || s == 5) ? strobe_hold : 8'd0;
          queue_byte(init_seq[s], 1'b0, (s == 0) ? power_up_wait : 8'd0,
                     extra, s == 5);
        end
      end
      lcdnws_pkg::CMD_INSTRUCTION: begin
        queue_byte(r.value, 1'b0, 8'd0, 8'd0, 1'b1);
      end
      lcdnws_pkg::CMD_CHARACTER: begin
        queue_byte(r.value, 1'b1, 8'd0, 8'd0, 1'b1);
      end
      default: begin
        // a cursor on any other line gives nothing
        if (r.line == lcdnws_pkg::LINE_ONE) begin
          queue_byte(lcdnws_pkg::CURSOR_LINE_ONE | (r.column & lcdnws_pkg::COLUMN_MASK),
                     1'b0, 8'd0, 8'd0, 1'b1);
        end else if (r.line == lcdnws_pkg::LINE_TWO) begin
          queue_byte(lcdnws_pkg::CURSOR_LINE_TWO | (r.column & lcdnws_pkg::COLUMN_MASK),
                     1'b0, 8'd0, 8'd0, 1'b1);
        end
      end
    endcase
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Match a departing pin state against the oldest expectation
  function void check_pin(lcdnws_pkg::pin_t got);
    lcdnws_pkg::pin_t want;
    if (expected_pins.size() == 0) begin
      $display("%0t: pin state with nothing expected, expected none actual %h",
               $time, got);
      mismatches++;
      return;
    end
    want = expected_pins.pop_front();
    compare_field("data_nibble", 8'(want.data_nibble), 8'(got.data_nibble));
    compare_field("register_select", 8'(want.register_select), 8'(got.register_select));
    compare_field("enable_level", 8'(want.enable_level), 8'(got.enable_level));
    compare_field("read_write", 8'(want.read_write), 8'(got.read_write));
    compare_field("settle_before_ms", want.settle_before_ms, got.settle_before_ms);
    compare_field("hold_ms", want.hold_ms, got.hold_ms);
    compare_field("last", 8'(want.last), 8'(got.last));
  endfunction

  function int unsigned pending();
    return expected_pins.size();
  endfunction
endclass

module char_lcd_nibble_write_sequencer_unit_tb;

  localparam int unsigned TailCycles     = 12;
  localparam int unsigned DeepHoldCycles = 200;
  localparam int unsigned TimeoutCycles  = 1_000_000;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned ItemsPerPhase  = 45;
  localparam int unsigned PressurePhase  = 3;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  lcdnws_pkg::req_t               in_req    = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  lcdnws_pkg::pin_t               out_pin;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [lcdnws_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data  = '0;

  int unsigned tx_gap_odds   = 0;
  int unsigned rx_stall_odds = 0;
  bit          deep_hold_req = 1'b0;

  lcd_pin_scoreboard board = new();

  char_lcd_nibble_write_sequencer_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_pin),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic lcdnws_pkg::req_t make_request(lcdnws_pkg::command_e c, logic [7:0] v,
                                                    logic [7:0] ln, logic [7:0] col);
    lcdnws_pkg::req_t r;
    r.command = c;
    r.value   = v;
    r.line    = ln;
    r.column  = col;
    return r;
  endfunction

  // Mostly byte and cursor requests; power-up is long, so keep it rare
  function automatic lcdnws_pkg::req_t random_request();
    lcdnws_pkg::req_t r;
    r.command = ($urandom_range(0, 11) == 0) ?
                lcdnws_pkg::CMD_POWER_UP :
                lcdnws_pkg::command_e'($urandom_range(1, 3));
    r.value   = 8'($urandom_range(0, 255));
    r.column  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) begin
      r.line = 8'($urandom_range(0, 255));
    end else begin
      r.line = $urandom_range(0, 1) ? lcdnws_pkg::LINE_TWO : lcdnws_pkg::LINE_ONE;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_setting();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer a request and hold it until taken; valid stays up for the caller
  task automatic send_request(lcdnws_pkg::req_t r);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_request(r);
  endtask

  // Drop valid, with junk on the idle payload
  task automatic idle_input(int unsigned n);
    in_valid <= 1'b0;
    in_req   <= random_request();
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every expected pin state is out and the block is quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Write one register; valid stays up for the caller to drop
  task automatic write_register(logic [lcdnws_pkg::CfgIdxW-1:0] index, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.note_register(index, data);
  endtask

  task automatic set_timing(logic [7:0] strobe, logic [7:0] wait_ms);
    write_register(lcdnws_pkg::CFG_STROBE_HOLD, strobe);
    write_register(lcdnws_pkg::CFG_POWER_UP_WAIT, wait_ms);
    cfg_valid <= 1'b0;
  endtask

  // Unused index: the timing registers must not change
  task automatic write_unused(logic [7:0] data);
    write_register(lcdnws_pkg::CfgIdxW'($urandom_range(lcdnws_pkg::CFG_POWER_UP_WAIT + 1, 255)),
                   data);
    cfg_valid <= 1'b0;
  endtask

  // Result side: check each transaction and stall in random bursts
  initial begin : pin_sink
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        board.check_pin(out_pin);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (deep_hold_req) begin
        deep_hold_req = 1'b0;
        stall_left    = DeepHoldCycles - 1;
        out_stall    <= 1'b1;
      end else if (rx_stall_odds != 0 && $urandom_range(1, 100) <= rx_stall_odds) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    repeat (TimeoutCycles) @(posedge clk);
    $display("char_lcd_nibble_write_sequencer_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    lcdnws_pkg::req_t r;
    int unsigned      acting;
    bit               quiet;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset timing, byte extremes, clear, cursor corners
    send_request(make_request(lcdnws_pkg::CMD_POWER_UP, 8'h00, 8'h00, 8'h00));
    send_request(make_request(lcdnws_pkg::CMD_INSTRUCTION, 8'h00, 8'hFF, 8'hFF));
    send_request(make_request(lcdnws_pkg::CMD_INSTRUCTION, 8'hFF, 8'h00, 8'h00));
    send_request(make_request(lcdnws_pkg::CMD_INSTRUCTION, 8'h01, 8'h01, 8'h00));
    send_request(make_request(lcdnws_pkg::CMD_CHARACTER, 8'h00, 8'h02, 8'h0F));
    send_request(make_request(lcdnws_pkg::CMD_CHARACTER, 8'hFF, 8'h00, 8'h00));
    send_request(make_request(lcdnws_pkg::CMD_CHARACTER, 8'hA5, 8'h5A, 8'hA5));
    send_request(make_request(lcdnws_pkg::CMD_SET_CURSOR, 8'hFF, lcdnws_pkg::LINE_ONE, 8'hFF));
    send_request(make_request(lcdnws_pkg::CMD_SET_CURSOR, 8'h00, lcdnws_pkg::LINE_TWO, 8'h00));
    send_request(make_request(lcdnws_pkg::CMD_SET_CURSOR, 8'h00, lcdnws_pkg::LINE_TWO, 8'h5A));
    send_request(make_request(lcdnws_pkg::CMD_SET_CURSOR, 8'h00, 8'h00, 8'h03));
    send_request(make_request(lcdnws_pkg::CMD_SET_CURSOR, 8'h00, 8'h03, 8'h03));
    send_request(make_request(lcdnws_pkg::CMD_SET_CURSOR, 8'h00, 8'hFF, 8'hF0));
    settle_block();

    // Largest timing: extra holds saturate
    set_timing(8'd255, 8'd255);
    send_request(make_request(lcdnws_pkg::CMD_POWER_UP, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_request(lcdnws_pkg::CMD_INSTRUCTION, 8'h5A, 8'h00, 8'h00));
    settle_block();

    // Zero timing
    set_timing(8'd0, 8'd0);
    send_request(make_request(lcdnws_pkg::CMD_POWER_UP, 8'h00, 8'h00, 8'h00));
    send_request(make_request(lcdnws_pkg::CMD_CHARACTER, 8'hC3, 8'h00, 8'h00));
    settle_block();

    // Saturation boundary, and an unused index that must change nothing
    set_timing(8'd128, 8'd1);
    write_unused(8'h55);
    send_request(make_request(lcdnws_pkg::CMD_POWER_UP, 8'h00, 8'h00, 8'h00));
    settle_block();
    set_timing(8'd127, 8'd254);
    send_request(make_request(lcdnws_pkg::CMD_POWER_UP, 8'h00, 8'h00, 8'h00));
    settle_block();

    // Random phases; the last one runs without any idling
    for (int ph = 0; ph < RandomPhases; ph++) begin
      quiet = (ph == RandomPhases - 1);
      set_timing(pick_setting(), pick_setting());
      if ($urandom_range(0, 3) == 0) begin
        write_unused(8'($urandom_range(0, 255)));
      end
      tx_gap_odds   = quiet ? 0 : $urandom_range(0, 3) * 10;
      rx_stall_odds = quiet ? 0 : $urandom_range(0, 3) * 5;
      if (ph == PressurePhase) begin
        // stream back to back into a long receiver hold
        tx_gap_odds   = 0;
        deep_hold_req = 1'b1;
      end
      acting = 0;
      while (acting < ItemsPerPhase) begin
        r = random_request();
        send_request(r);
        if (!(r.command == lcdnws_pkg::CMD_SET_CURSOR &&
              r.line != lcdnws_pkg::LINE_ONE && r.line != lcdnws_pkg::LINE_TWO)) begin
          acting++;
        end
        if (tx_gap_odds != 0 && $urandom_range(1, 100) <= tx_gap_odds) begin
          idle_input($urandom_range(1, 18));
        end
      end
      settle_block();
    end

    if (board.mismatches == 0) begin
      $display("char_lcd_nibble_write_sequencer_unit verification clean");
    end else begin
      $display("char_lcd_nibble_write_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
